// ----- design/center_weighted_3x3_blur_macros.svh -----
// assertion macros of the center weighted 3x3 blur
`ifndef CENTER_WEIGHTED_3X3_BLUR_MACROS_SVH
`define CENTER_WEIGHTED_3X3_BLUR_MACROS_SVH
`ifndef SYNTHESIS
// condition and consequence in the same cycle
`define CWB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// consequence in the cycle after the condition
`define CWB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CWB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define CWB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- design/cwb_pkg.sv -----
// shared types, constants and helpers of the center weighted 3x3 blur
package cwb_pkg;

  localparam int unsigned MAX_LINE_DEF = 1024;
  localparam int unsigned MAX_ROWS_DEF = 4096;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned FW_W       = 11;
  localparam int unsigned FH_W       = 13;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // divider datapath
  localparam int unsigned SUM_W       = 13;
  localparam int unsigned DIV_W       = 5;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;
  localparam int unsigned QUO_W       = PROD_W - RECIP_SHIFT;
  localparam int unsigned QD_W        = QUO_W + DIV_W;

  localparam logic [DIV_W-1:0] CENTER_WEIGHT = 5'd9;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pix_t;

  // where the pixel to emit sits in the frame
  typedef struct packed {
    logic emit;
    logic top;
    logic bottom;
    logic left;
    logic right;
    logic last;
  } pos_flags_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_end;
  } res_t;

  // floor(2^16 / d) for the divisors that occur
  function automatic logic [RECIP_W-1:0] recip(input logic [DIV_W-1:0] d);
    logic [RECIP_W-1:0] m;
    case (d)
      5'd9:    m = 13'd7281;
      5'd10:   m = 13'd6553;
      5'd11:   m = 13'd5957;
      5'd12:   m = 13'd5461;
      5'd13:   m = 13'd5041;
      5'd14:   m = 13'd4681;
      5'd15:   m = 13'd4369;
      5'd16:   m = 13'd4096;
      5'd17:   m = 13'd3855;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ----- design/cwb_ram.sv -----
// generic single write port ram with registered read
module cwb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/cwb_fifo.sv -----
// small register queue
module cwb_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr & ~full;
  assign do_rd = rd & ~empty;
  assign rdata = mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- design/cwb_front.sv -----
// front end: takes items, drops idle pads, tracks frame position
module cwb_front #(
  parameter int unsigned MAX_LINE = cwb_pkg::MAX_LINE_DEF,
  parameter int unsigned MAX_ROWS = cwb_pkg::MAX_ROWS_DEF,
  localparam int unsigned LW  = $clog2(MAX_LINE + 1),
  localparam int unsigned HW  = $clog2(MAX_ROWS + 1),
  localparam int unsigned CW  = $clog2(MAX_LINE),
  localparam int unsigned RI  = $clog2(MAX_ROWS),
  localparam int unsigned LDW = $clog2(MAX_LINE + 2)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     restart,
  input  logic [LW-1:0]            eff_w,
  input  logic [HW-1:0]            eff_h,
  input  logic                     push,
  input  logic [cwb_pkg::PIX_W-1:0] in_pix_red,
  input  logic [cwb_pkg::PIX_W-1:0] in_pix_green,
  input  logic [cwb_pkg::PIX_W-1:0] in_pix_blue,
  input  logic                     in_is_pad,
  input  logic                     q_full,
  output logic                     q_push,
  output cwb_pkg::pix_t            q_pix,
  output logic [CW-1:0]            q_col,
  output cwb_pkg::pos_flags_t      q_flags
);

  import cwb_pkg::*;

  logic [CW-1:0]  in_col_r, in_col_nxt;
  logic [RI-1:0]  in_row_r, in_row_nxt;
  logic           pix_done_r, pix_done_nxt;
  logic [LDW-1:0] lead_r, lead_nxt;
  logic [RI-1:0]  em_row_r, em_row_nxt;
  logic [CW-1:0]  em_col_r, em_col_nxt;

  logic take, col_wrap, last_pix, emit, em_wrap, em_last_row, fend;

  // classify the incoming item
  assign take        = push & ~q_full & ~(~pix_done_r & in_is_pad);
  assign col_wrap    = (LW'(in_col_r) == eff_w - 1'b1);
  assign last_pix    = col_wrap & (HW'(in_row_r) == eff_h - 1'b1);
  assign emit        = (lead_r == LDW'(eff_w) + 1'b1);
  assign em_wrap     = (LW'(em_col_r) == eff_w - 1'b1);
  assign em_last_row = (HW'(em_row_r) == eff_h - 1'b1);
  assign fend        = emit & em_wrap & em_last_row;

  // item to the back end
  assign q_push         = take;
  assign q_pix          = pix_done_r ? '0 : {in_pix_red, in_pix_green, in_pix_blue};
  assign q_col          = in_col_r;
  assign q_flags.emit   = emit;
  assign q_flags.top    = (em_row_r == '0);
  assign q_flags.bottom = em_last_row;
  assign q_flags.left   = (em_col_r == '0);
  assign q_flags.right  = em_wrap;
  assign q_flags.last   = fend;

  // position counters
  always_comb begin
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    pix_done_nxt = pix_done_r;
    lead_nxt     = lead_r;
    em_row_nxt   = em_row_r;
    em_col_nxt   = em_col_r;
    if (take) begin
      in_col_nxt = col_wrap ? '0 : in_col_r + 1'b1;
      if (!pix_done_r) begin
        if (col_wrap) begin
          in_row_nxt = in_row_r + 1'b1;
        end
        if (last_pix) begin
          pix_done_nxt = 1'b1;
        end
      end
      if (!emit) begin
        lead_nxt = lead_r + 1'b1;
      end else begin
        em_col_nxt = em_wrap ? '0 : em_col_r + 1'b1;
        if (em_wrap) begin
          em_row_nxt = em_row_r + 1'b1;
        end
      end
    end
    // new frame after the last output or a register write
    if (restart || (take && fend)) begin
      in_col_nxt   = '0;
      in_row_nxt   = '0;
      pix_done_nxt = 1'b0;
      lead_nxt     = '0;
      em_row_nxt   = '0;
      em_col_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      pix_done_r <= 1'b0;
      lead_r     <= '0;
      em_row_r   <= '0;
      em_col_r   <= '0;
    end else begin
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      pix_done_r <= pix_done_nxt;
      lead_r     <= lead_nxt;
      em_row_r   <= em_row_nxt;
      em_col_r   <= em_col_nxt;
    end
  end

endmodule

// ----- design/cwb_back.sv -----
// back end: line buffer, 3x3 window, weighted sum and divide
module cwb_back #(
  parameter int unsigned MAX_LINE = cwb_pkg::MAX_LINE_DEF,
  localparam int unsigned CW = $clog2(MAX_LINE)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  output logic                q_pop,
  input  cwb_pkg::pix_t       q_pix,
  input  logic [CW-1:0]       q_col,
  input  cwb_pkg::pos_flags_t q_flags,
  input  logic                o_full,
  output logic                o_push,
  output cwb_pkg::res_t       o_res
);

  import cwb_pkg::*;

  localparam int unsigned PW = $bits(pix_t);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SHIFT = 5'b00010,
    ST_SUM   = 5'b00100,
    ST_MUL   = 5'b01000,
    ST_DIV   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  pix_t            cur_pix_r;
  logic [CW-1:0]   cur_col_r;
  pos_flags_t      cur_flags_r;
  pix_t            win_r [3][3];
  logic [SUM_W-1:0]  sum_r  [3];
  logic [SUM_W-1:0]  sum_nxt [3];
  logic [DIV_W-1:0]  div_r, div_nxt;
  logic [PROD_W-1:0] prod_r [3];
  logic [PIX_W-1:0]  quo [3];

  logic          ram_re, ram_we;
  logic [2*PW-1:0] ram_rdata;
  pix_t          line_up1, line_up2;

  function automatic logic [PIX_W-1:0] chan(input pix_t p, input int unsigned k);
    logic [PIX_W-1:0] v;
    case (k)
      0:       v = p.red;
      1:       v = p.green;
      default: v = p.blue;
    endcase
    return v;
  endfunction

  // line buffer: upper half one line back, lower half two lines back
  cwb_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_LINE)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_col_r),
    .wdata ({cur_pix_r, line_up1}),
    .re    (ram_re),
    .raddr (q_col),
    .rdata (ram_rdata)
  );

  assign line_up1 = ram_rdata[2*PW-1:PW];
  assign line_up2 = ram_rdata[PW-1:0];

  // sequencer
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    o_push    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          ram_re    = 1'b1;
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        ram_we    = 1'b1;
        state_nxt = cur_flags_r.emit ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!o_full) begin
          o_push    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // clipped weighted sums and divisor
  always_comb begin
    logic [2:0]       row_ok;
    logic [2:0]       col_ok;
    logic [CNT_W-1:0] cnt;
    logic [PIX_W-1:0] ctr;
    row_ok = {~cur_flags_r.bottom, 1'b1, ~cur_flags_r.top};
    col_ok = {~cur_flags_r.right, 1'b1, ~cur_flags_r.left};
    cnt    = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!(r == 1 && c == 1) && row_ok[r] && col_ok[c]) begin
          cnt = cnt + 1'b1;
        end
      end
    end
    div_nxt = CENTER_WEIGHT + DIV_W'(cnt);
    for (int k = 0; k < 3; k++) begin
      ctr        = chan(win_r[1][1], k);
      sum_nxt[k] = SUM_W'({ctr, 3'b000}) + SUM_W'(ctr);
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (!(r == 1 && c == 1) && row_ok[r] && col_ok[c]) begin
            sum_nxt[k] = sum_nxt[k] + SUM_W'(chan(win_r[r][c], k));
          end
        end
      end
    end
  end

  // quotient by reciprocal with one correction step
  always_comb begin
    logic [QUO_W-1:0] q0;
    logic [QD_W-1:0]  qd;
    logic [QD_W-1:0]  rem;
    for (int k = 0; k < 3; k++) begin
      q0     = prod_r[k][PROD_W-1:RECIP_SHIFT];
      qd     = QD_W'(q0) * QD_W'(div_r);
      rem    = QD_W'(sum_r[k]) - qd;
      quo[k] = (rem >= QD_W'(div_r)) ? PIX_W'(q0 + 1'b1) : PIX_W'(q0);
    end
  end

  assign o_res.red       = quo[0];
  assign o_res.green     = quo[1];
  assign o_res.blue      = quo[2];
  assign o_res.frame_end = cur_flags_r.last;

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_pix_r   <= q_pix;
      cur_col_r   <= q_col;
      cur_flags_r <= q_flags;
    end
    if (state_r == ST_SHIFT) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= line_up2;
      win_r[1][2] <= line_up1;
      win_r[2][2] <= cur_pix_r;
    end
    if (state_r == ST_SUM) begin
      for (int k = 0; k < 3; k++) begin
        sum_r[k] <= sum_nxt[k];
      end
      div_r <= div_nxt;
    end
    if (state_r == ST_MUL) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= PROD_W'(sum_r[k]) * PROD_W'(recip(div_r));
      end
    end
  end

endmodule

// ----- design/center_weighted_3x3_blur.sv -----
// top level of the center weighted 3x3 blur
// path: an item goes through the mid queue, the back end sequencer and the result queue
// the sequencer steps idle and shift, then sum, mul and div for an item with a result, and
// takes no new item before the last is done; div waits while the result queue is full
// reset: synchronous active low, registers to 640 x 480, counters and queues cleared
`include "center_weighted_3x3_blur_macros.svh"
module center_weighted_3x3_blur #(
  parameter int unsigned MAX_LINE = cwb_pkg::MAX_LINE_DEF,
  parameter int unsigned MAX_ROWS = cwb_pkg::MAX_ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           push,
  output logic                           full,
  input  logic [cwb_pkg::PIX_W-1:0]      in_pix_red,
  input  logic [cwb_pkg::PIX_W-1:0]      in_pix_green,
  input  logic [cwb_pkg::PIX_W-1:0]      in_pix_blue,
  input  logic                           in_is_pad,
  // result channel
  output logic                           empty,
  input  logic                           pop,
  output logic [cwb_pkg::PIX_W-1:0]      out_red,
  output logic [cwb_pkg::PIX_W-1:0]      out_green,
  output logic [cwb_pkg::PIX_W-1:0]      out_blue,
  output logic                           out_frame_end,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cwb_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [cwb_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [cwb_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  import cwb_pkg::*;

  localparam int unsigned LW = $clog2(MAX_LINE + 1);
  localparam int unsigned HW = $clog2(MAX_ROWS + 1);
  localparam int unsigned CW = $clog2(MAX_LINE);
  localparam int unsigned MW = $bits(pix_t) + CW + $bits(pos_flags_t);

  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;
  logic            cfg_wr;
  logic            reg_idx;
  logic [LW-1:0]   eff_w;
  logic [HW-1:0]   eff_h;

  logic          q_push, q_full, q_pop, q_empty;
  pix_t          f_pix, b_pix;
  logic [CW-1:0] f_col, b_col;
  pos_flags_t    f_flags, b_flags;
  logic [MW-1:0] q_rdata;

  logic o_push, o_full;
  res_t o_res, out_res;

  // register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FRAME_WIDTH:  frame_width_r  <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= pwdata[FH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH:  prdata = CFG_DATA_W'(frame_width_r);
      REG_FRAME_HEIGHT: prdata = CFG_DATA_W'(frame_height_r);
      default:          prdata = '0;
    endcase
  end

  // frame size clamped to the supported range
  always_comb begin
    if (frame_width_r == '0) begin
      eff_w = LW'(1);
    end else if (32'(frame_width_r) > MAX_LINE) begin
      eff_w = LW'(MAX_LINE);
    end else begin
      eff_w = LW'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      eff_h = HW'(1);
    end else if (32'(frame_height_r) > MAX_ROWS) begin
      eff_h = HW'(MAX_ROWS);
    end else begin
      eff_h = HW'(frame_height_r);
    end
  end

  // front end
  cwb_front #(
    .MAX_LINE (MAX_LINE),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .restart      (cfg_wr),
    .eff_w        (eff_w),
    .eff_h        (eff_h),
    .push         (push),
    .in_pix_red   (in_pix_red),
    .in_pix_green (in_pix_green),
    .in_pix_blue  (in_pix_blue),
    .in_is_pad    (in_is_pad),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_pix        (f_pix),
    .q_col        (f_col),
    .q_flags      (f_flags)
  );

  assign full = q_full;

  // queue between front and back
  cwb_fifo #(
    .WIDTH (MW),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_push),
    .wdata ({f_pix, f_col, f_flags}),
    .full  (q_full),
    .rd    (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign {b_pix, b_col, b_flags} = q_rdata;

  // back end
  cwb_back #(
    .MAX_LINE (MAX_LINE)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_pix   (b_pix),
    .q_col   (b_col),
    .q_flags (b_flags),
    .o_full  (o_full),
    .o_push  (o_push),
    .o_res   (o_res)
  );

  // result queue
  cwb_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (o_push),
    .wdata (o_res),
    .full  (o_full),
    .rd    (pop),
    .rdata (out_res),
    .empty (empty)
  );

  assign out_red       = out_res.red;
  assign out_green     = out_res.green;
  assign out_blue      = out_res.blue;
  assign out_frame_end = out_res.frame_end;

  // checks
  `CWB_ASSERT_IMP(a_out_room, clk, rst_n, o_push, !o_full, "result pushed into full queue")
  `CWB_ASSERT_IMP(a_mid_avail, clk, rst_n, q_pop, !q_empty, "back end popped empty queue")
  `CWB_ASSERT_NXT(a_one_at_a_time, clk, rst_n, q_pop, !q_pop, "back end took two items in a row")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// testbench of the center weighted 3x3 blur: predicted smoothing checked item by item
module tb;
  import cwb_pkg::*;

  localparam int unsigned RING_DEPTH    = 2 * MAX_LINE_DEF + 4;
  localparam int unsigned ITEM_TARGET   = 1800;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned GAP_MAX       = 13;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned WIDE_PHASE    = 3;
  localparam int unsigned FULL_FRAME_MAX = 250;
  localparam int unsigned TIMEOUT_NS    = 5_000_000;

  // tracks the pixel stream and predicts every smoothed pixel
  class blur_tracker;
    pix_t            ring [RING_DEPTH];
    int unsigned     ring_pos;
    int unsigned     taken;
    int unsigned     emitted;
    int unsigned     col;
    int unsigned     row;
    logic [FW_W-1:0] width_reg;
    logic [FH_W-1:0] height_reg;
    res_t            smoothed_q [$];
    int unsigned     errors;
    int unsigned     checked;
    int unsigned     frames;

    function new();
      ring_pos   = 0;
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      errors     = 0;
      checked    = 0;
      frames     = 0;
      rewind();
    endfunction

    function void rewind();
      taken   = 0;
      emitted = 0;
      col     = 0;
      row     = 0;
    endfunction

    function int unsigned line_len();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_LINE_DEF) return MAX_LINE_DEF;
      return width_reg;
    endfunction

    function int unsigned frame_rows();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_ROWS_DEF) return MAX_ROWS_DEF;
      return height_reg;
    endfunction

    // any register write starts a new frame
    function void write_reg(logic idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_FRAME_WIDTH) width_reg = value[FW_W-1:0];
      else height_reg = value[FH_W-1:0];
      rewind();
    endfunction

    // returns 0 when the block ignores the item
    function bit take_item(pix_t px, logic pad);
      int unsigned w, h, total, newest, wt;
      int unsigned sum_r, sum_g, sum_b, wsum;
      int          r, c, lag, idx;
      pix_t        val, nb;
      res_t        want;
      w     = line_len();
      h     = frame_rows();
      total = w * h;
      val   = '0;
      // pixel phase: pads are dropped; flush phase: every item is a flush
      if (taken < total) begin
        if (pad) return 0;
        val = px;
      end
      newest       = ring_pos;
      ring[newest] = val;
      ring_pos     = (ring_pos + 1 == RING_DEPTH) ? 0 : ring_pos + 1;
      taken++;
      if (taken < w + 2) return 1;

      // clipped window, center weighted
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      wsum  = 0;
      for (int dr = -1; dr <= 1; dr++) begin
        r = int'(row) + dr;
        if (r < 0 || r >= int'(h)) continue;
        for (int dc = -1; dc <= 1; dc++) begin
          c = int'(col) + dc;
          if (c < 0 || c >= int'(w)) continue;
          lag   = int'(w) + 1 - dr * int'(w) - dc;
          idx   = (int'(newest) + int'(RING_DEPTH) - lag) % int'(RING_DEPTH);
          nb    = ring[idx];
          wt    = (dr == 0 && dc == 0) ? CENTER_WEIGHT : 1;
          sum_r += nb.red * wt;
          sum_g += nb.green * wt;
          sum_b += nb.blue * wt;
          wsum  += wt;
        end
      end
      want.red   = 8'(sum_r / wsum);
      want.green = 8'(sum_g / wsum);
      want.blue  = 8'(sum_b / wsum);

      // advance the emit position, wrap at the end of the frame
      emitted++;
      want.frame_end = 1'b0;
      if (emitted >= total) begin
        want.frame_end = 1'b1;
        rewind();
      end else begin
        col++;
        if (col >= w) begin
          col = 0;
          row++;
        end
      end
      smoothed_q.push_back(want);
      return 1;
    endfunction

    function void compare(string name, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
      if (got !== want) begin
        $error("tb: %s expected %0d actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(res_t got);
      res_t want;
      if (smoothed_q.size() == 0) begin
        $error("tb: result with no pixel pending: %0d %0d %0d frame_end %0b",
               got.red, got.green, got.blue, got.frame_end);
        errors++;
        return;
      end
      want = smoothed_q.pop_front();
      checked++;
      compare("out_red", want.red, got.red);
      compare("out_green", want.green, got.green);
      compare("out_blue", want.blue, got.blue);
      compare("out_frame_end", PIX_W'(want.frame_end), PIX_W'(got.frame_end));
      if (want.frame_end) frames++;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  logic [PIX_W-1:0]      in_pix_red = '0;
  logic [PIX_W-1:0]      in_pix_green = '0;
  logic [PIX_W-1:0]      in_pix_blue = '0;
  logic                  in_is_pad = 1'b0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [PIX_W-1:0]      out_red;
  logic [PIX_W-1:0]      out_green;
  logic [PIX_W-1:0]      out_blue;
  logic                  out_frame_end;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  blur_tracker blur = new();
  int unsigned items_used = 0;
  int unsigned stall_cycles = 0;
  int unsigned push_gap_max = GAP_MAX;
  int unsigned pop_gap_max = GAP_MAX;
  bit          hold_req = 1'b0;

  center_weighted_3x3_blur i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_pix_red   (in_pix_red),
    .in_pix_green (in_pix_green),
    .in_pix_blue  (in_pix_blue),
    .in_is_pad    (in_is_pad),
    .empty        (empty),
    .pop          (pop),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_frame_end(out_frame_end),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // count cycles where the block holds off the input
  always @(posedge clk) begin
    if (rst_n && push && full === 1'b1) stall_cycles++;
  end

  // channels near the extremes more often than uniform
  function automatic pix_t random_pix();
    pix_t px;
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(0, 5) == 0) px[8*k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else px[8*k +: 8] = 8'($urandom);
    end
    return px;
  endfunction

  // one item on the input channel, entered and left at a falling edge
  task automatic send_item(input pix_t px, input logic pad);
    int unsigned gap;
    gap = $urandom_range(0, push_gap_max);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push         <= 1'b1;
    in_pix_red   <= px.red;
    in_pix_green <= px.green;
    in_pix_blue  <= px.blue;
    in_is_pad    <= pad;
    @(posedge clk);
    while (full !== 1'b0) @(posedge clk);
    if (blur.take_item(px, pad)) items_used++;
    @(negedge clk);
  endtask

  // pixels with stray pads mixed in, then the flush items if asked
  task automatic send_frame(input int unsigned w, input int unsigned npix, input bit flush);
    for (int unsigned p = 0; p < npix; p++) begin
      if ($urandom_range(0, 15) == 0) send_item(random_pix(), 1'b1);
      send_item(random_pix(), 1'b0);
    end
    if (flush) begin
      for (int unsigned p = 0; p <= w; p++) send_item(random_pix(), $urandom_range(0, 3) != 0);
    end
  endtask

  // register write then read back
  task automatic set_register(input logic idx, input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    blur.write_reg(idx, value);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    want = '0;
    if (idx == REG_FRAME_WIDTH) want[FW_W-1:0] = value[FW_W-1:0];
    else want[FH_W-1:0] = value[FH_W-1:0];
    if (prdata !== want) begin
      $error("tb: prdata expected %0d actual %0d", want, prdata);
      blur.errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // both registers in random order, junk in the unused upper bits
  task automatic configure(input int unsigned w_val, input int unsigned h_val);
    logic [CFG_DATA_W-1:0] w_word, h_word;
    w_word = CFG_DATA_W'(w_val) | ($urandom << FW_W);
    h_word = CFG_DATA_W'(h_val) | ($urandom << FH_W);
    if ($urandom_range(0, 1)) begin
      set_register(REG_FRAME_WIDTH, w_word);
      set_register(REG_FRAME_HEIGHT, h_word);
    end else begin
      set_register(REG_FRAME_HEIGHT, h_word);
      set_register(REG_FRAME_WIDTH, w_word);
    end
  endtask

  // all predicted pixels out, then let the pipeline settle
  task automatic wait_idle();
    push <= 1'b0;
    while (blur.smoothed_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // result side, with one long hold-off to fill the block
  initial begin : result_side
    int unsigned gap;
    bit          held;
    held = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (!held && hold_req) begin
        gap  = HOLD_CYCLES;
        held = 1'b1;
      end else begin
        if (blur.checked % 32 == 0) pop_gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
        gap = $urandom_range(0, pop_gap_max);
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty !== 1'b0) @(posedge clk);
      blur.check_pixel({out_red, out_green, out_blue, out_frame_end});
      @(negedge clk);
    end
  end

  // stimulus
  initial begin : stimulus
    int unsigned phase, w_eff, h_eff, pixels, nframes, w_val, h_val, pick;
    pix_t        px;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single pixel frame from zero registers, stray pad first, a pixel as flush
    configure(0, 0);
    send_item(random_pix(), 1'b1);
    send_item('1, 1'b0);
    send_item(random_pix(), 1'b0);
    send_item(random_pix(), 1'b1);
    wait_idle();

    // 3x3 frame: corners, edges and center, pad inside, pixel among the flush
    configure(3, 3);
    for (int p = 0; p < 9; p++) begin
      px = (p % 2 == 0) ? '1 : '0;
      if (p == 4) px = random_pix();
      send_item(px, 1'b0);
      if (p == 4) send_item(random_pix(), 1'b1);
    end
    for (int p = 0; p < 4; p++) send_item(random_pix(), p != 2);
    send_item(random_pix(), 1'b1);
    wait_idle();

    // 4x4 frame while the result side holds off after its first pixel
    configure(4, 4);
    hold_req = 1'b1;
    send_frame(4, 16, 1'b1);
    wait_idle();

    // random settings, mostly small frames, a few huge ones cut short
    phase = 0;
    while (items_used < ITEM_TARGET) begin
      phase++;
      push_gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
      if (phase == WIDE_PHASE) begin
        w_val = 2047;
        h_val = $urandom_range(2, 8191);
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            w_val = $urandom_range(0, 2);
            pick  = $urandom_range(0, 2);
            h_val = (pick == 0) ? 4096 : (pick == 1) ? 8191 : $urandom_range(4097, 8190);
          end
          1: begin
            w_val = $urandom_range(9, 40);
            h_val = $urandom_range(1, 4);
          end
          default: begin
            w_val = $urandom_range(0, 8);
            h_val = $urandom_range(0, 6);
          end
        endcase
      end
      configure(w_val, h_val);
      w_eff  = blur.line_len();
      h_eff  = blur.frame_rows();
      pixels = w_eff * h_eff;
      if (pixels + w_eff + 1 <= FULL_FRAME_MAX) begin
        nframes = $urandom_range(1, 3);
        for (int f = 0; f < nframes; f++) begin
          // now and then the last frame is cut short and dropped by the next write
          if (f == nframes - 1 && $urandom_range(0, 7) == 0) begin
            send_frame(w_eff, $urandom_range(1, pixels), 1'b0);
          end else begin
            send_frame(w_eff, pixels, 1'b1);
            if ($urandom_range(0, 5) == 0) send_item(random_pix(), 1'b1);
          end
        end
      end else begin
        send_frame(w_eff, w_eff + 2 + $urandom_range(0, 29), 1'b0);
      end
      wait_idle();
    end

    $display("tb: %0d items over %0d register settings, %0d smoothed pixels checked, %0d frames",
             items_used, phase, blur.checked, blur.frames);
    $display("tb: input held off by the block on %0d cycles", stall_cycles);
    if (blur.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb: done, errors");
    $finish;
  end

endmodule

// ----- center_weighted_3x3_blur.f -----
+incdir+design
design/cwb_pkg.sv
design/cwb_ram.sv
design/cwb_fifo.sv
design/cwb_front.sv
design/cwb_back.sv
design/center_weighted_3x3_blur.sv
tb/tb.sv
